FILE: rtl/c2c_pkg.sv
// shared constants, types and the arctangent table for the cartesian to cylindrical converter
package c2c_pkg;

  // default number of cordic rotations
  localparam int CORDIC_STAGES_DEF = 24;

  // guard bits added below the magnitudes before rotation
  localparam int GUARD_BITS = 16;

  // cordic datapath: signed x/y width and signed q2.30 angle accumulator width
  localparam int CW = 51;
  localparam int AW = 33;

  // angle constants in q2.30
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;

  // largest azimuth code in q3.29
  localparam logic [31:0] AZIMUTH_MAX = 32'd3373259426;

  // square root: one result bit per step, remainder never exceeds twice the root
  localparam int SQRT_STEPS = 32;
  localparam int REM_W      = 34;

  // rotation state carried between cordic stages
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [AW-1:0] acc;
  } cordic_state_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      root;
    logic [63:0]      rad;
  } sqrt_state_t;

  // per item side information that travels down the pipeline
  typedef struct packed {
    logic [31:0] z;
    logic        xneg;
    logic        yneg;
    logic        zero;
  } meta_t;

  // one finished result
  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] azimuth;
    logic [31:0] height;
  } result_t;

  // atan(2^-idx) in q2.30, rounded to nearest
  function automatic logic [31:0] c2c_atan(input int idx);
    logic [31:0] val;
    case (idx)
      0: val = 32'd843314857;
      1: val = 32'd497837829;
      2: val = 32'd263043837;
      3: val = 32'd133525159;
      4: val = 32'd67021687;
      5: val = 32'd33543516;
      6: val = 32'd16775851;
      7: val = 32'd8388437;
      8: val = 32'd4194283;
      9: val = 32'd2097149;
      default: begin
        if (idx <= 30) val = 32'd1 << (30 - idx);
        else val = 32'd0;
      end
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/c2c_sqrt_stage.sv
// one restoring square root step: two radicand bits in, one root bit out
module c2c_sqrt_stage
  import c2c_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  sqrt_state_t d,
  output sqrt_state_t q
);

  logic [REM_W+1:0] shifted;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             take;

  // trial subtraction of 4*root + 1
  always_comb begin
    shifted = {d.rem, d.rad[63:62]};
    trial   = {2'b00, d.root, 2'b01};
    diff    = shifted - trial;
    take    = (shifted >= trial);
  end

  // step register
  always_ff @(posedge clk) begin
    if (en) begin
      q.rem  <= take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      q.root <= {d.root[30:0], take};
      q.rad  <= {d.rad[61:0], 2'b00};
    end
  end

endmodule

FILE: rtl/c2c_cordic_stage.sv
// one cordic vectoring rotation with a fixed shift
module c2c_cordic_stage
  import c2c_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  cordic_state_t d,
  output cordic_state_t q
);

  localparam logic signed [AW-1:0] ATAN_STEP = {{(AW-32){1'b0}}, c2c_atan(SHIFT)};

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  // floor shifts of the cross terms
  always_comb begin
    dx = d.cy >>> SHIFT;
    dy = d.cx >>> SHIFT;
  end

  // rotate towards the x axis, steering on the sign of y
  always_ff @(posedge clk) begin
    if (en) begin
      if (!d.cy[CW-1]) begin
        q.cx  <= d.cx + dx;
        q.cy  <= d.cy - dy;
        q.acc <= d.acc + ATAN_STEP;
      end else begin
        q.cx  <= d.cx - dx;
        q.cy  <= d.cy + dy;
        q.acc <= d.acc - ATAN_STEP;
      end
    end
  end

endmodule

FILE: rtl/c2c_skid.sv
// output register with a one-entry skid buffer
module c2c_skid
  import c2c_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    p_valid,
  input  result_t p_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t skid_data;

  // control: output slot and skid slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (full) begin
        out_valid <= 1'b1;
        full      <= 1'b0;
      end else begin
        out_valid <= p_valid;
      end
    end else if (p_valid && !full) begin
      full <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= full ? skid_data : p_data;
    end
    if (out_valid && out_stall && !full) begin
      skid_data <= p_data;
    end
  end

endmodule

FILE: rtl/cartesian_to_cylindrical.sv
// top level: pipelined cartesian (x, y, z) to cylindrical (radius, azimuth, height)
//
// Input channel: in_valid / in_stall with x_coord, y_coord, z_coord (signed q16.16).
// A point transfers on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with radius (unsigned q16.16), azimuth
// (unsigned q3.29 radians in [0, 2*pi]) and height (copy of z).
// Radius is the rounded square root of x*x + y*y, from two 32x32 multipliers,
// an adder and a 32 step digit-by-digit root. Azimuth comes from a CORDIC_STAGES
// deep vectoring cordic on |x|, |y| followed by quadrant placement.
// Radius and azimuth are delayed to line up at the end of the longer of the square
// root chain and the cordic chain.
// Throughput is one point per cycle unless stalled; every stage is a register
// with a valid bit. When the receiver stalls, a one-entry skid stage takes the
// next result and in_stall rises as it fills; the whole pipeline then holds
// until the output drains. No transfer is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and the skid slot, not the output
// data; the block accepts a point in the first cycle after reset.
module cartesian_to_cylindrical
  import c2c_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [31:0] radius,
  output logic        [31:0] azimuth,
  output logic signed [31:0] height
);

  localparam int RAD_AT = 3 + SQRT_STEPS;
  localparam int AZ_AT  = CORDIC_STAGES + 1;
  localparam int LAST   = (RAD_AT > AZ_AT) ? RAD_AT : AZ_AT;

  logic          en;
  logic          full;
  logic          vld [0:LAST];
  meta_t         meta [0:LAST];
  logic [31:0]   abs_x;
  logic [31:0]   abs_y;
  logic [63:0]   sq_xx;
  logic [63:0]   sq_yy;
  logic [63:0]   sq;
  cordic_state_t cst [0:CORDIC_STAGES];
  sqrt_state_t   sst [0:SQRT_STEPS];
  logic [31:0]   rad_pipe [RAD_AT:LAST];
  logic [31:0]   az_pipe [AZ_AT:LAST];
  logic [30:0]   t_clamp;
  logic [33:0]   az_sum;
  logic [31:0]   az_fold;
  result_t       p_data;
  result_t       out_data;

  // whole pipeline moves while the skid slot is free
  assign en       = !full;
  assign in_stall = full;

  // entry stage: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_x        <= x_coord[31] ? (~x_coord + 32'd1) : x_coord;
      abs_y        <= y_coord[31] ? (~y_coord + 32'd1) : y_coord;
      meta[0].z    <= z_coord;
      meta[0].xneg <= x_coord[31];
      meta[0].yneg <= y_coord[31];
      meta[0].zero <= (x_coord == 32'sd0) && (y_coord == 32'sd0);
    end
  end

  // valid and side information line
  genvar k;
  generate
    for (k = 1; k <= LAST; k++) begin : g_meta
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          meta[k] <= meta[k-1];
        end
      end
    end
  endgenerate

  // radius: squares, then sum
  always_ff @(posedge clk) begin
    if (en) begin
      sq_xx <= 64'(abs_x) * 64'(abs_x);
      sq_yy <= 64'(abs_y) * 64'(abs_y);
      sq    <= sq_xx + sq_yy;
    end
  end

  // radius: square root chain
  assign sst[0] = '{rem: '0, root: '0, rad: sq};

  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      c2c_sqrt_stage u_sqrt (
        .clk (clk),
        .en  (en),
        .d   (sst[k]),
        .q   (sst[k+1])
      );
    end
  endgenerate

  // radius: round to nearest, ties upward
  always_ff @(posedge clk) begin
    if (en) begin
      rad_pipe[RAD_AT] <= (sst[SQRT_STEPS].rem > {2'b00, sst[SQRT_STEPS].root}) ?
                          sst[SQRT_STEPS].root + 32'd1 : sst[SQRT_STEPS].root;
    end
  end

  generate
    for (k = RAD_AT + 1; k <= LAST; k++) begin : g_rad_pad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_pipe[k] <= rad_pipe[k-1];
        end
      end
    end
  endgenerate

  // azimuth: cordic on the first-quadrant vector
  assign cst[0] = '{
    cx:  {{(CW-32-GUARD_BITS){1'b0}}, abs_x, {GUARD_BITS{1'b0}}},
    cy:  {{(CW-32-GUARD_BITS){1'b0}}, abs_y, {GUARD_BITS{1'b0}}},
    acc: '0
  };

  generate
    for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      c2c_cordic_stage #(
        .SHIFT (k)
      ) u_cordic (
        .clk (clk),
        .en  (en),
        .d   (cst[k]),
        .q   (cst[k+1])
      );
    end
  endgenerate

  // azimuth: clamp to [0, pi/2], place in quadrant, round q2.30 to q3.29; a zero point gives 0
  always_comb begin
    if (cst[CORDIC_STAGES].acc[AW-1]) begin
      t_clamp = '0;
    end else if (cst[CORDIC_STAGES].acc > $signed({1'b0, HALF_PI_Q30[AW-2:0]})) begin
      t_clamp = HALF_PI_Q30[30:0];
    end else begin
      t_clamp = cst[CORDIC_STAGES].acc[30:0];
    end

    if (!meta[CORDIC_STAGES].xneg && !meta[CORDIC_STAGES].yneg) begin
      az_sum = 34'd1 + {3'b000, t_clamp};
    end else if (meta[CORDIC_STAGES].xneg && !meta[CORDIC_STAGES].yneg) begin
      az_sum = (PI_Q30 + 34'd1) - {3'b000, t_clamp};
    end else if (meta[CORDIC_STAGES].xneg) begin
      az_sum = (PI_Q30 + 34'd1) + {3'b000, t_clamp};
    end else begin
      az_sum = (TWO_PI_Q30 + 34'd1) - {3'b000, t_clamp};
    end

    az_fold = meta[CORDIC_STAGES].zero ? 32'd0 : az_sum[32:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_pipe[AZ_AT] <= az_fold;
    end
  end

  generate
    for (k = AZ_AT + 1; k <= LAST; k++) begin : g_az_pad
      always_ff @(posedge clk) begin
        if (en) begin
          az_pipe[k] <= az_pipe[k-1];
        end
      end
    end
  endgenerate

  // output register and skid stage
  assign p_data = '{radius: rad_pipe[LAST], azimuth: az_pipe[LAST], height: meta[LAST].z};

  c2c_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .p_valid   (vld[LAST]),
    .p_data    (p_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign radius  = out_data.radius;
  assign azimuth = out_data.azimuth;
  assign height  = out_data.height;

endmodule

FILE: rtl/c2c_checker.sv
// port-level checker for the cartesian to cylindrical converter, with its bind
module c2c_checker
  import c2c_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic        [31:0] radius,
  input logic        [31:0] azimuth,
  input logic signed [31:0] height
);

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // input only backs up after the output was held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held output");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(radius) && $stable(azimuth)
                               && $stable(height))
    else $error("held result changed");

  // azimuth never exceeds a full turn
  a_az_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> azimuth <= AZIMUTH_MAX)
    else $error("azimuth out of range");

endmodule

bind cartesian_to_cylindrical c2c_checker u_c2c_checker (.*);
